FILE: hdl/vmt_pkg.sv
// ----------------------------------------------------------------------------
// vmt_pkg: shared types and constants of the 4x4 vector transform
// Fixed-point widths, mode codes, register indexes and matrix reset values.
// ----------------------------------------------------------------------------
package vmt_pkg;

	localparam int unsigned COMP_W  = 32;  // Q16.16 vector component
	localparam int unsigned COEF_W  = 16;  // Q4.12 matrix coefficient
	localparam int unsigned PROD_W  = COMP_W + COEF_W;      // exact product
	localparam int unsigned SUM_W   = PROD_W + 2;           // sum of four products
	localparam int unsigned FRAC_SH = 12;                   // Q22.28 sum -> Q16.16
	localparam int unsigned SHR_W   = SUM_W - FRAC_SH;      // shifted sum width
	localparam int unsigned ROW_W   = 4 * COEF_W;
	localparam int unsigned IDX_W   = 3;

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic        [ROW_W-1:0]  row_t;
	typedef logic        [IDX_W-1:0]  reg_idx_t;

	typedef enum logic [1:0] {
		CMD_KEEP  = 2'd0,
		CMD_POINT = 2'd1,
		CMD_DIR   = 2'd2
	} cmd_t;

	localparam reg_idx_t REG_ROW0 = 3'd0;
	localparam reg_idx_t REG_ROW1 = 3'd1;
	localparam reg_idx_t REG_ROW2 = 3'd2;
	localparam reg_idx_t REG_ROW3 = 3'd3;

	localparam row_t ROW0_RST = 64'h0000_0000_0000_1000;
	localparam row_t ROW1_RST = 64'h0000_0000_1000_0000;
	localparam row_t ROW2_RST = 64'h0000_1000_0000_0000;
	localparam row_t ROW3_RST = 64'h1000_0000_0000_0000;

	localparam comp_t W_ONE  = 32'sh0001_0000;
	localparam comp_t W_ZERO = 32'sh0000_0000;
	localparam comp_t COMP_MAX = 32'sh7FFF_FFFF;
	localparam comp_t COMP_MIN = 32'sh8000_0000;

	// Handshake between the top level and one pipeline stage
	typedef struct packed {
		logic adv;       // stage register may load this cycle
		logic valid_in;  // upstream stage holds an item
	} pipe_ctl_t;

endpackage

FILE: hdl/vector_matrix_transform_4x4.sv
// ----------------------------------------------------------------------------
// vector_matrix_transform_4x4: row vector times 4x4 fixed-point matrix
// Q16.16 vector by Q4.12 matrix, floor-scaled and clamped to Q16.16.
// ----------------------------------------------------------------------------
// A vector transfer enters every clock unless in_stall is high; its result
// passes input register, sixteen parallel multipliers, column adders, then the
// scale-and-clamp register that drives the output. Each stage holds one item
// and loads whenever the stage after it is empty or moving, so empty slots
// close up during an output stall and in_stall rises only once all four stages
// are full and out_stall is high. cmd selects w: keep vec_w (also for the
// unused code three), force 1.0 for points or 0.0 for directions. Each output
// is the exact sum of four products shifted right by twelve (toward minus
// infinity) and clamped; saturated flags any clamped component. The matrix is
// four 64-bit rows written by index on the cfg port, which is always ready;
// indexes four and above are dropped. Write the matrix only while the
// pipeline is empty. Reset loads the identity matrix.
// ----------------------------------------------------------------------------
module vector_matrix_transform_4x4 (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          cmd,
	input  logic signed [31:0]  vec_x,
	input  logic signed [31:0]  vec_y,
	input  logic signed [31:0]  vec_z,
	input  logic signed [31:0]  vec_w,

	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  out_x,
	output logic signed [31:0]  out_y,
	output logic signed [31:0]  out_z,
	output logic signed [31:0]  out_w,
	output logic                saturated,

	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data
);

	// Matrix registers
	vmt_pkg::row_t rows [4];

	assign cfg_ready = 1'b1;

	vmt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid && cfg_ready),
		.wr_idx  (cfg_index),
		.wr_data (cfg_data),
		.rows    (rows)
	);

	// Stage advance chain: a stage loads when empty or when its successor moves
	logic adv_s1, adv_s2, adv_s3, adv_s4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	assign adv_s4   = !valid_s4 || !out_stall;
	assign adv_s3   = !valid_s3 || adv_s4;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// Stage 1: capture the vector and resolve w from the mode
	vmt_pkg::comp_t vec_s1 [4];
	vmt_pkg::comp_t w_sel;

	always_comb begin
		case (vmt_pkg::cmd_t'(cmd))
			vmt_pkg::CMD_POINT: w_sel = vmt_pkg::W_ONE;
			vmt_pkg::CMD_DIR:   w_sel = vmt_pkg::W_ZERO;
			default:            w_sel = vec_w;  // keep w, also for the unused code
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			vec_s1[0] <= vec_x;
			vec_s1[1] <= vec_y;
			vec_s1[2] <= vec_z;
			vec_s1[3] <= w_sel;
		end
	end

	// Stage 2: products
	vmt_pkg::pipe_ctl_t ctl_s2, ctl_s3, ctl_s4;
	vmt_pkg::prod_t     prod [4][4];

	assign ctl_s2 = '{adv: adv_s2, valid_in: valid_s1};

	vmt_mult u_mult (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s2),
		.vec    (vec_s1),
		.rows   (rows),
		.valid  (valid_s2),
		.prod   (prod)
	);

	// Stage 3: column sums
	vmt_pkg::sum_t sum [4];

	assign ctl_s3 = '{adv: adv_s3, valid_in: valid_s2};

	vmt_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s3),
		.prod   (prod),
		.valid  (valid_s3),
		.sum    (sum)
	);

	// Stage 4: scale, clamp and hold for the output transfer
	vmt_pkg::comp_t res [4];

	assign ctl_s4 = '{adv: adv_s4, valid_in: valid_s3};

	vmt_sat u_sat (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s4),
		.sum    (sum),
		.valid  (valid_s4),
		.res    (res),
		.sat    (saturated)
	);

	assign out_valid = valid_s4;
	assign out_x     = res[0];
	assign out_y     = res[1];
	assign out_z     = res[2];
	assign out_w     = res[3];

	// Back-pressure only once every stage holds an item behind a stalled output
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && out_stall))
		else $error("input stalled with an empty pipeline slot");

	// An accepted input transfer always lands in stage 1
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted input transfer lost");

	// A clamped result carries a full-scale component
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |->
			(out_x == vmt_pkg::COMP_MAX || out_x == vmt_pkg::COMP_MIN ||
			 out_y == vmt_pkg::COMP_MAX || out_y == vmt_pkg::COMP_MIN ||
			 out_z == vmt_pkg::COMP_MAX || out_z == vmt_pkg::COMP_MIN ||
			 out_w == vmt_pkg::COMP_MAX || out_w == vmt_pkg::COMP_MIN))
		else $error("saturated flag without a clamped component");

endmodule

FILE: hdl/vmt_cfg.sv
// ----------------------------------------------------------------------------
// vmt_cfg: matrix register file
// Four 64-bit rows of packed Q4.12 coefficients, written by index.
// ----------------------------------------------------------------------------
module vmt_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  vmt_pkg::reg_idx_t   wr_idx,
	input  vmt_pkg::row_t       wr_data,
	output vmt_pkg::row_t       rows [4]
);

	vmt_pkg::row_t row_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= vmt_pkg::ROW0_RST;
			row_q[1] <= vmt_pkg::ROW1_RST;
			row_q[2] <= vmt_pkg::ROW2_RST;
			row_q[3] <= vmt_pkg::ROW3_RST;
		end else if (wr_en) begin
			case (wr_idx)
				vmt_pkg::REG_ROW0: row_q[0] <= wr_data;
				vmt_pkg::REG_ROW1: row_q[1] <= wr_data;
				vmt_pkg::REG_ROW2: row_q[2] <= wr_data;
				vmt_pkg::REG_ROW3: row_q[3] <= wr_data;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	assign rows = row_q;

endmodule

FILE: hdl/vmt_mult.sv
// ----------------------------------------------------------------------------
// vmt_mult: product stage
// Sixteen 32x16 signed multipliers, one per vector component and column.
// ----------------------------------------------------------------------------
module vmt_mult (
	input  logic                clk,
	input  logic                arst_n,
	input  vmt_pkg::pipe_ctl_t  ctl,
	input  vmt_pkg::comp_t      vec [4],
	input  vmt_pkg::row_t       rows [4],
	output logic                valid,
	output vmt_pkg::prod_t      prod [4][4]   // [column][row]
);

	logic           valid_s2;
	vmt_pkg::prod_t prod_s2 [4][4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ctl.adv) begin
			valid_s2 <= ctl.valid_in;
		end
	end

	for (genvar c = 0; c < 4; c++) begin : g_col
		for (genvar k = 0; k < 4; k++) begin : g_row
			vmt_pkg::coef_t coef;
			assign coef = $signed(rows[k][c*vmt_pkg::COEF_W +: vmt_pkg::COEF_W]);

			always_ff @(posedge clk) begin
				if (ctl.adv && ctl.valid_in) begin
					prod_s2[c][k] <= vmt_pkg::prod_t'(vec[k]) * vmt_pkg::prod_t'(coef);
				end
			end
		end
	end

	assign valid = valid_s2;
	assign prod  = prod_s2;

endmodule

FILE: hdl/vmt_acc.sv
// ----------------------------------------------------------------------------
// vmt_acc: column sum stage
// Adds the four exact products of each column into a 50-bit Q22.28 sum.
// ----------------------------------------------------------------------------
module vmt_acc (
	input  logic                clk,
	input  logic                arst_n,
	input  vmt_pkg::pipe_ctl_t  ctl,
	input  vmt_pkg::prod_t      prod [4][4],
	output logic                valid,
	output vmt_pkg::sum_t       sum [4]
);

	logic          valid_s3;
	vmt_pkg::sum_t sum_s3 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ctl.adv) begin
			valid_s3 <= ctl.valid_in;
		end
	end

	for (genvar c = 0; c < 4; c++) begin : g_col
		always_ff @(posedge clk) begin
			if (ctl.adv && ctl.valid_in) begin
				sum_s3[c] <= vmt_pkg::sum_t'(prod[c][0]) + vmt_pkg::sum_t'(prod[c][1])
					+ vmt_pkg::sum_t'(prod[c][2]) + vmt_pkg::sum_t'(prod[c][3]);
			end
		end
	end

	assign valid = valid_s3;
	assign sum   = sum_s3;

endmodule

FILE: hdl/vmt_sat.sv
// ----------------------------------------------------------------------------
// vmt_sat: scale and clamp stage
// Floor-shifts each sum back to Q16.16 and clamps it to 32 bits.
// ----------------------------------------------------------------------------
module vmt_sat (
	input  logic                clk,
	input  logic                arst_n,
	input  vmt_pkg::pipe_ctl_t  ctl,
	input  vmt_pkg::sum_t       sum [4],
	output logic                valid,
	output vmt_pkg::comp_t      res [4],
	output logic                sat
);

	logic                       valid_s4;
	vmt_pkg::comp_t             res_s4 [4];
	logic                       sat_s4;
	vmt_pkg::comp_t             res_c [4];
	logic [3:0]                 clip;

	for (genvar c = 0; c < 4; c++) begin : g_col
		vmt_pkg::sum_t              shr;
		logic [vmt_pkg::SHR_W-1:0]  sh;
		logic [vmt_pkg::SHR_W-vmt_pkg::COMP_W:0] top;

		// arithmetic shift rounds toward minus infinity
		assign shr = sum[c] >>> vmt_pkg::FRAC_SH;
		assign sh  = shr[vmt_pkg::SHR_W-1:0];
		assign top = sh[vmt_pkg::SHR_W-1:vmt_pkg::COMP_W-1];

		assign clip[c]  = !((&top) || !(|top));
		assign res_c[c] = !clip[c] ? $signed(sh[vmt_pkg::COMP_W-1:0])
			: (sh[vmt_pkg::SHR_W-1] ? vmt_pkg::COMP_MIN : vmt_pkg::COMP_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ctl.adv) begin
			valid_s4 <= ctl.valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv && ctl.valid_in) begin
			res_s4 <= res_c;
			sat_s4 <= |clip;
		end
	end

	assign valid = valid_s4;
	assign res   = res_s4;
	assign sat   = sat_s4;

endmodule

FILE: bench/vector_matrix_transform_4x4_test.sv
// ----------------------------------------------------------------------------
// vector_matrix_transform_4x4_test: self-checking bench of the 4x4 transform
// Drives vector transfers and matrix writes with random idling on both sides,
// predicts every result from a private copy of the matrix and compares each
// output transfer field by field, oldest expectation first.
// ----------------------------------------------------------------------------
module vector_matrix_transform_4x4_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Mode code three has no name in the package; the block treats it as keep
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Register indexes past the last row: the block drops writes to these
	localparam vmt_pkg::reg_idx_t REG_NONE_LO = 3'd4;
	localparam vmt_pkg::reg_idx_t REG_NONE_HI = 3'd7;

	localparam vmt_pkg::coef_t COEF_ONE    = 16'sh1000;
	localparam vmt_pkg::coef_t COEF_ZERO   = 16'sh0000;
	localparam vmt_pkg::coef_t COEF_TOP    = 16'sh7FFF;
	localparam vmt_pkg::coef_t COEF_BOTTOM = 16'sh8000;

	localparam vmt_pkg::comp_t NEG_ONE = 32'shFFFF_FFFF;

	localparam vmt_pkg::row_t ROW_TOP    = 64'h7FFF_7FFF_7FFF_7FFF;
	localparam vmt_pkg::row_t ROW_BOTTOM = 64'h8000_8000_8000_8000;
	localparam vmt_pkg::row_t ROW_LSB    = 64'h0000_0000_0000_0001;
	localparam vmt_pkg::row_t ROW_ZERO   = 64'h0000_0000_0000_0000;
	localparam vmt_pkg::row_t ROW_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 229;
	localparam int STALL_LIMIT  = 400;   // cycles without any transfer

	typedef enum int {
		MAT_IDENT,
		MAT_FULL,
		MAT_MILD,
		MAT_TOP,
		MAT_BOTTOM,
		MAT_MIXED
	} mat_style_t;

	typedef struct packed {
		logic [1:0]     mode;
		vmt_pkg::comp_t x;
		vmt_pkg::comp_t y;
		vmt_pkg::comp_t z;
		vmt_pkg::comp_t w;
	} vec_in_t;

	typedef struct packed {
		vmt_pkg::comp_t x;
		vmt_pkg::comp_t y;
		vmt_pkg::comp_t z;
		vmt_pkg::comp_t w;
		logic           sat;
	} vec_out_t;

	// One row of the directed table: either a register write or a vector
	typedef struct {
		bit                is_cfg;
		vmt_pkg::reg_idx_t idx;
		vmt_pkg::row_t     data;
		vec_in_t           v;
		bit                known;   // result typed into the table, not predicted
		vec_out_t          want;
	} plan_step_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        cmd;
	vmt_pkg::comp_t    vec_x;
	vmt_pkg::comp_t    vec_y;
	vmt_pkg::comp_t    vec_z;
	vmt_pkg::comp_t    vec_w;
	logic              out_valid;
	logic              out_stall;
	vmt_pkg::comp_t    out_x;
	vmt_pkg::comp_t    out_y;
	vmt_pkg::comp_t    out_z;
	vmt_pkg::comp_t    out_w;
	logic              saturated;
	logic              cfg_valid;
	logic              cfg_ready;
	vmt_pkg::reg_idx_t cfg_index;
	vmt_pkg::row_t     cfg_data;

	// Private copy of the matrix, updated on every accepted write
	vmt_pkg::row_t matrix [4];
	// Results still owed by the block, oldest first
	vec_out_t      outstanding [$];
	int            errors;
	bit            source_calm;
	bit            sink_calm;

	vector_matrix_transform_4x4 dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Checking helpers
	// ------------------------------------------------------------------------

	// Print one line per failure and count it
	task automatic report(input string msg);
		errors++;
		$display("[%0t] %s", $time, msg);
	endtask

	task automatic check_lane(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report($sformatf("%s is %h, %h was due", name, got, want));
		end
	endtask

	// ------------------------------------------------------------------------
	// Predictor: row vector times the held matrix, floor-scaled and clamped
	// ------------------------------------------------------------------------
	function automatic vec_out_t transform(input vec_in_t v);
		longint         comp [4];
		longint         acc;
		vmt_pkg::coef_t k;
		vmt_pkg::comp_t lane [4];
		logic           clamp;
		int             col;
		int             row;
		vec_out_t       r;
		comp[0] = longint'(signed'(v.x));
		comp[1] = longint'(signed'(v.y));
		comp[2] = longint'(signed'(v.z));
		comp[3] = longint'(signed'(v.w));
		// Points take w = 1.0, directions w = 0; keep and code three keep w
		if (v.mode == vmt_pkg::CMD_POINT) begin
			comp[3] = longint'(vmt_pkg::W_ONE);
		end else if (v.mode == vmt_pkg::CMD_DIR) begin
			comp[3] = longint'(vmt_pkg::W_ZERO);
		end
		clamp = 1'b0;
		for (col = 0; col < 4; col++) begin
			acc = 0;
			for (row = 0; row < 4; row++) begin
				k = matrix[row][16*col +: 16];
				acc += comp[row] * longint'(k);
			end
			// Arithmetic shift rounds toward minus infinity
			acc = acc >>> vmt_pkg::FRAC_SH;
			if (acc > longint'(vmt_pkg::COMP_MAX)) begin
				lane[col] = vmt_pkg::COMP_MAX;
				clamp = 1'b1;
			end else if (acc < longint'(vmt_pkg::COMP_MIN)) begin
				lane[col] = vmt_pkg::COMP_MIN;
				clamp = 1'b1;
			end else begin
				lane[col] = vmt_pkg::comp_t'(acc);
			end
		end
		r.x = lane[0];
		r.y = lane[1];
		r.z = lane[2];
		r.w = lane[3];
		r.sat = clamp;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Table builders
	// ------------------------------------------------------------------------
	function automatic plan_step_t reg_step(input vmt_pkg::reg_idx_t idx,
			input vmt_pkg::row_t data);
		plan_step_t s;
		s.is_cfg = 1'b1;
		s.idx = idx;
		s.data = data;
		s.v = '0;
		s.known = 1'b0;
		s.want = '0;
		return s;
	endfunction

	function automatic plan_step_t vec_step(input logic [1:0] mode,
			input vmt_pkg::comp_t x, input vmt_pkg::comp_t y,
			input vmt_pkg::comp_t z, input vmt_pkg::comp_t w);
		plan_step_t s;
		s.is_cfg = 1'b0;
		s.idx = vmt_pkg::REG_ROW0;
		s.data = ROW_ZERO;
		s.v = '{mode, x, y, z, w};
		s.known = 1'b0;
		s.want = '0;
		return s;
	endfunction

	function automatic plan_step_t vec_known(input logic [1:0] mode,
			input vmt_pkg::comp_t x, input vmt_pkg::comp_t y,
			input vmt_pkg::comp_t z, input vmt_pkg::comp_t w,
			input vmt_pkg::comp_t ox, input vmt_pkg::comp_t oy,
			input vmt_pkg::comp_t oz, input vmt_pkg::comp_t ow, input logic sat);
		plan_step_t s;
		s = vec_step(mode, x, y, z, w);
		s.known = 1'b1;
		s.want = '{ox, oy, oz, ow, sat};
		return s;
	endfunction

	// ------------------------------------------------------------------------
	// Random content
	// ------------------------------------------------------------------------
	function automatic vmt_pkg::comp_t pick_comp();
		case ($urandom_range(0, 7))
			0: return vmt_pkg::COMP_MAX;
			1: return vmt_pkg::COMP_MIN;
			2: return vmt_pkg::comp_t'($urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
			3: return vmt_pkg::W_ZERO;
			default: return vmt_pkg::comp_t'($urandom);
		endcase
	endfunction

	function automatic vec_in_t random_vec();
		vec_in_t v;
		v.mode = 2'($urandom_range(0, 3));
		v.x = pick_comp();
		v.y = pick_comp();
		v.z = pick_comp();
		v.w = pick_comp();
		return v;
	endfunction

	function automatic vmt_pkg::coef_t pick_coef(input mat_style_t style,
			input int row, input int col);
		case (style)
			MAT_IDENT:  return (row == col) ? COEF_ONE : COEF_ZERO;
			MAT_FULL:   return vmt_pkg::coef_t'($urandom);
			MAT_MILD:   return vmt_pkg::coef_t'($urandom_range(0, 32'h2000) - 32'h1000);
			MAT_TOP:    return COEF_TOP;
			MAT_BOTTOM: return COEF_BOTTOM;
			default: begin
				case ($urandom_range(0, 4))
					0: return COEF_TOP;
					1: return COEF_BOTTOM;
					2: return COEF_ZERO;
					3: return COEF_ONE;
					default: return vmt_pkg::coef_t'($urandom);
				endcase
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// Present one vector after a random gap, hold it until the transfer, then
	// book its expected result. in_valid stays high for a back-to-back item.
	task automatic send_vec(input vec_in_t v, input vec_out_t want);
		int gap;
		if ($urandom_range(0, 39) == 0) begin
			source_calm = !source_calm;
		end
		gap = source_calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= v.mode;
		vec_x    <= v.x;
		vec_y    <= v.y;
		vec_z    <= v.z;
		vec_w    <= v.w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		outstanding.push_back(want);
	endtask

	// Drop in_valid and wait until every booked result has arrived
	task automatic drain_results();
		in_valid <= 1'b0;
		while (outstanding.size() != 0) @(posedge clk);
	endtask

	// Hold one register write until it transfers; the caller drops cfg_valid
	// after the last write of a batch so that valid is never toggled in a step
	task automatic write_reg(input vmt_pkg::reg_idx_t idx, input vmt_pkg::row_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx <= vmt_pkg::REG_ROW3) begin
			matrix[idx[1:0]] = data;
		end
	endtask

	// Write all four rows in a rotated order, sometimes with a dropped write
	// to an unused index slipped in between
	task automatic load_matrix(input mat_style_t style);
		int            first;
		int            n;
		int            row;
		int            col;
		vmt_pkg::row_t value;
		first = $urandom_range(0, 3);
		for (n = 0; n < 4; n++) begin
			row = (first + n) % 4;
			for (col = 0; col < 4; col++) begin
				value[16*col +: 16] = pick_coef(style, row, col);
			end
			write_reg(vmt_pkg::REG_ROW0 + vmt_pkg::reg_idx_t'(row), value);
			if (n == 1 && $urandom_range(0, 1) == 1) begin
				write_reg(vmt_pkg::reg_idx_t'($urandom_range(REG_NONE_LO, REG_NONE_HI)),
					{$urandom, $urandom});
			end
		end
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Result sink: stall at random, then take one transfer and check it
	// ------------------------------------------------------------------------
	initial begin : sink
		int       hold;
		vec_out_t want;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 39) == 0) begin
				sink_calm = !sink_calm;
			end
			hold = sink_calm ? 0 : $urandom_range(0, 6);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (outstanding.size() == 0) begin
				report("result transfer with no result outstanding");
			end else begin
				want = outstanding.pop_front();
				check_lane("out_x", out_x, want.x);
				check_lane("out_y", out_y, want.y);
				check_lane("out_z", out_z, want.z);
				check_lane("out_w", out_w, want.w);
				check_lane("saturated", {31'b0, saturated}, {31'b0, want.sat});
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run once nothing has transferred for too long
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus: directed table first, then random phases
	// ------------------------------------------------------------------------
	initial begin : stimulus
		plan_step_t plan [$];
		vec_out_t   want;
		vec_in_t    v;
		int         i;
		int         phase;
		int         n;
		mat_style_t style;

		errors      = 0;
		source_calm = 1'b0;
		sink_calm   = 1'b0;
		matrix      = '{vmt_pkg::ROW0_RST, vmt_pkg::ROW1_RST, vmt_pkg::ROW2_RST,
			vmt_pkg::ROW3_RST};

		// Every input known from time zero
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		cmd       <= vmt_pkg::CMD_KEEP;
		vec_x     <= vmt_pkg::W_ZERO;
		vec_y     <= vmt_pkg::W_ZERO;
		vec_z     <= vmt_pkg::W_ZERO;
		vec_w     <= vmt_pkg::W_ZERO;
		out_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= vmt_pkg::REG_ROW0;
		cfg_data  <= ROW_ZERO;

		// Directed table. Under the reset identity matrix every result can be
		// read straight off the input; so can the clamped extremes.
		plan = '{
			// identity: pass-through, w kept
			vec_known(vmt_pkg::CMD_KEEP, 32'sh0001_0000, 32'sh0002_0000,
				32'sh0003_0000, 32'sh0004_0000, 32'sh0001_0000, 32'sh0002_0000,
				32'sh0003_0000, 32'sh0004_0000, 1'b0),
			// point: w forced to one whatever vec_w holds
			vec_known(vmt_pkg::CMD_POINT, vmt_pkg::COMP_MAX, vmt_pkg::COMP_MIN,
				vmt_pkg::W_ZERO, 32'sh1234_5678, vmt_pkg::COMP_MAX,
				vmt_pkg::COMP_MIN, vmt_pkg::W_ZERO, vmt_pkg::W_ONE, 1'b0),
			// direction: w forced to zero
			vec_known(vmt_pkg::CMD_DIR, NEG_ONE, 32'sh5555_5555, 32'shAAAA_AAAA,
				vmt_pkg::COMP_MAX, NEG_ONE, 32'sh5555_5555, 32'shAAAA_AAAA,
				vmt_pkg::W_ZERO, 1'b0),
			// unused mode code behaves like keep
			vec_known(CMD_UNUSED, 32'sh0000_0001, 32'sh8000_0001, 32'sh7FFF_FFFE,
				32'shDEAD_BEEF, 32'sh0000_0001, 32'sh8000_0001, 32'sh7FFF_FFFE,
				32'shDEAD_BEEF, 1'b0),
			vec_known(vmt_pkg::CMD_KEEP, vmt_pkg::COMP_MAX, vmt_pkg::COMP_MAX,
				vmt_pkg::COMP_MAX, vmt_pkg::COMP_MAX, vmt_pkg::COMP_MAX,
				vmt_pkg::COMP_MAX, vmt_pkg::COMP_MAX, vmt_pkg::COMP_MAX, 1'b0),
			vec_known(vmt_pkg::CMD_KEEP, vmt_pkg::COMP_MIN, vmt_pkg::COMP_MIN,
				vmt_pkg::COMP_MIN, vmt_pkg::COMP_MIN, vmt_pkg::COMP_MIN,
				vmt_pkg::COMP_MIN, vmt_pkg::COMP_MIN, vmt_pkg::COMP_MIN, 1'b0),
			// write to an unused index must leave the identity in place
			reg_step(REG_NONE_LO, ROW_ZERO),
			vec_known(vmt_pkg::CMD_KEEP, 32'sh0000_0005, 32'sh0000_0006,
				32'sh0000_0007, 32'sh0000_0008, 32'sh0000_0005, 32'sh0000_0006,
				32'sh0000_0007, 32'sh0000_0008, 1'b0),
			// largest positive coefficients: overflow both ways
			reg_step(vmt_pkg::REG_ROW0, ROW_TOP),
			reg_step(vmt_pkg::REG_ROW1, ROW_TOP),
			reg_step(vmt_pkg::REG_ROW2, ROW_TOP),
			reg_step(vmt_pkg::REG_ROW3, ROW_TOP),
			vec_known(vmt_pkg::CMD_KEEP, vmt_pkg::COMP_MAX, vmt_pkg::COMP_MAX,
				vmt_pkg::COMP_MAX, vmt_pkg::COMP_MAX, vmt_pkg::COMP_MAX,
				vmt_pkg::COMP_MAX, vmt_pkg::COMP_MAX, vmt_pkg::COMP_MAX, 1'b1),
			vec_known(vmt_pkg::CMD_KEEP, vmt_pkg::COMP_MIN, vmt_pkg::COMP_MIN,
				vmt_pkg::COMP_MIN, vmt_pkg::COMP_MIN, vmt_pkg::COMP_MIN,
				vmt_pkg::COMP_MIN, vmt_pkg::COMP_MIN, vmt_pkg::COMP_MIN, 1'b1),
			vec_step(vmt_pkg::CMD_POINT, 32'sh0000_0100, 32'shFFFF_FE00,
				32'sh0001_8000, NEG_ONE),
			// most negative coefficients: signs flip before the clamp
			reg_step(vmt_pkg::REG_ROW0, ROW_BOTTOM),
			reg_step(vmt_pkg::REG_ROW1, ROW_BOTTOM),
			reg_step(vmt_pkg::REG_ROW2, ROW_BOTTOM),
			reg_step(vmt_pkg::REG_ROW3, ROW_BOTTOM),
			vec_known(vmt_pkg::CMD_KEEP, vmt_pkg::COMP_MIN, vmt_pkg::COMP_MIN,
				vmt_pkg::COMP_MIN, vmt_pkg::COMP_MIN, vmt_pkg::COMP_MAX,
				vmt_pkg::COMP_MAX, vmt_pkg::COMP_MAX, vmt_pkg::COMP_MAX, 1'b1),
			vec_known(vmt_pkg::CMD_KEEP, vmt_pkg::COMP_MAX, vmt_pkg::COMP_MAX,
				vmt_pkg::COMP_MAX, vmt_pkg::COMP_MAX, vmt_pkg::COMP_MIN,
				vmt_pkg::COMP_MIN, vmt_pkg::COMP_MIN, vmt_pkg::COMP_MIN, 1'b1),
			vec_known(vmt_pkg::CMD_DIR, vmt_pkg::W_ZERO, vmt_pkg::W_ZERO,
				vmt_pkg::W_ZERO, vmt_pkg::COMP_MAX, vmt_pkg::W_ZERO,
				vmt_pkg::W_ZERO, vmt_pkg::W_ZERO, vmt_pkg::W_ZERO, 1'b0),
			vec_step(vmt_pkg::CMD_KEEP, 32'sh0001_0000, NEG_ONE, 32'sh0000_0001,
				32'sh0000_0002),
			// tiniest coefficient: the scaling floors toward minus infinity
			reg_step(vmt_pkg::REG_ROW0, ROW_LSB),
			reg_step(vmt_pkg::REG_ROW1, ROW_ZERO),
			reg_step(vmt_pkg::REG_ROW2, ROW_ZERO),
			reg_step(vmt_pkg::REG_ROW3, ROW_ZERO),
			vec_step(vmt_pkg::CMD_KEEP, NEG_ONE, vmt_pkg::W_ZERO, vmt_pkg::W_ZERO,
				vmt_pkg::W_ZERO),
			vec_step(vmt_pkg::CMD_KEEP, 32'sh0000_0001, vmt_pkg::W_ZERO,
				vmt_pkg::W_ZERO, vmt_pkg::W_ZERO),
			vec_step(vmt_pkg::CMD_POINT, 32'shFFFF_F001, vmt_pkg::COMP_MAX,
				vmt_pkg::COMP_MIN, vmt_pkg::W_ZERO),
			reg_step(REG_NONE_HI, ROW_ONES),
			vec_step(vmt_pkg::CMD_KEEP, NEG_ONE, vmt_pkg::COMP_MAX,
				vmt_pkg::COMP_MIN, NEG_ONE)
		};

		// Hold reset, then release it for good
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the table; drain the pipe before each write so it is idle
		for (i = 0; i < plan.size(); i++) begin
			if (plan[i].is_cfg) begin
				drain_results();
				write_reg(plan[i].idx, plan[i].data);
				if (i + 1 == plan.size() || !plan[i + 1].is_cfg) begin
					cfg_valid <= 1'b0;
				end
			end else begin
				want = plan[i].known ? plan[i].want : transform(plan[i].v);
				send_vec(plan[i].v, want);
			end
		end

		// Random phases: the first six walk every matrix style once, the
		// rest pick one at random
		for (phase = 0; phase < PHASES; phase++) begin
			drain_results();
			style = (phase < 6) ? mat_style_t'(phase)
				: mat_style_t'($urandom_range(MAT_IDENT, MAT_MIXED));
			load_matrix(style);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				v = random_vec();
				send_vec(v, transform(v));
				// pause the source once mid-stream until the pipe runs dry
				if (phase == 1 && n == PHASE_ITEMS / 2) begin
					drain_results();
				end
			end
		end

		// Let the last results out, then allow a few more cycles for strays
		drain_results();
		repeat (8) @(posedge clk);
		if (outstanding.size() != 0) begin
			report($sformatf("%0d results never arrived", outstanding.size()));
		end
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
